>>> sv/slrm_pkg.sv
// Shared types and constants of the stream liveness and rate monitor.
package slrm_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_DEAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_STALE = 2'd0,
    CFG_DEAD  = 2'd1,
    CFG_EMA   = 2'd2
  } cfg_idx_e;

  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_CHECK   = 1'b1;

  localparam int unsigned TIME_W = 63;
  localparam int unsigned RATE_W = 24;
  localparam int unsigned QUO_W  = 38;
  localparam logic [QUO_W-1:0] RATE_NUM = 38'd256000000000;
  localparam logic [RATE_W-1:0] RATE_MAX = 24'hFFFFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DIV,
    S_MUL,
    S_AVG,
    S_WRITE,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic read;
    logic eval;
    logic div_start;
    logic div_step;
    logic mul;
    logic avg;
    logic write;
    logic out_valid;
  } ctrl_t;

  typedef struct packed {
    logic idx_ok;
    logic need_div;
    logic div_done;
  } stat_t;

endpackage

>>> sv/slrm_stream_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface slrm_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  topic_index;
  logic [62:0] now_time;
  modport source (output valid, command, topic_index, now_time, input ready);
  modport sink (input valid, command, topic_index, now_time, output ready);
endinterface

interface slrm_out_if;
  logic        valid;
  logic        ready;
  logic        index_valid;
  logic [1:0]  stream_status;
  logic [23:0] rate_estimate;
  logic [62:0] last_arrival;
  logic [1:0]  system_status;
  modport source (output valid, index_valid, stream_status, rate_estimate,
                  last_arrival, system_status, input ready);
  modport sink (input valid, index_valid, stream_status, rate_estimate,
                last_arrival, system_status, output ready);
endinterface

>>> sv/slrm_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module slrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> sv/slrm_ctrl.sv
// Sequencer of the monitor: read, classify, divide, average, write back.
module slrm_ctrl import slrm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_READ;
      S_READ:  state_d = S_EVAL;
      S_EVAL:  begin
        if (!stat_i.idx_ok) state_d = S_OUT;
        else if (stat_i.need_div) state_d = S_DIV;
        else state_d = S_WRITE;
      end
      S_DIV:   if (stat_i.div_done) state_d = S_MUL;
      S_MUL:   state_d = S_AVG;
      S_AVG:   state_d = S_WRITE;
      S_WRITE: state_d = S_OUT;
      S_OUT:   if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE:  begin
        in_ready_o = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      S_READ:  ctrl_o.read = 1'b1;
      S_EVAL:  begin
        ctrl_o.eval = 1'b1;
        ctrl_o.div_start = stat_i.need_div;
      end
      S_DIV:   ctrl_o.div_step = 1'b1;
      S_MUL:   ctrl_o.mul = 1'b1;
      S_AVG:   ctrl_o.avg = 1'b1;
      S_WRITE: ctrl_o.write = 1'b1;
      S_OUT:   ctrl_o.out_valid = 1'b1;
      default: ctrl_o = '0;
    endcase
  end
endmodule

>>> sv/slrm_dp.sv
// Datapath of the monitor: stream stores, classifier, serial divider, averager.
module slrm_dp import slrm_pkg::*; #(
  parameter int unsigned STREAMS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  output stat_t             stat_o,
  input  logic              command_i,
  input  logic [7:0]        topic_index_i,
  input  logic [TIME_W-1:0] now_time_i,
  input  logic [31:0]       stale_thr_i,
  input  logic [31:0]       dead_thr_i,
  input  logic [15:0]       ema_w_i,
  output logic              index_valid_o,
  output logic [1:0]        stream_status_o,
  output logic [RATE_W-1:0] rate_estimate_o,
  output logic [TIME_W-1:0] last_arrival_o,
  output logic [1:0]        system_status_o
);
  localparam int unsigned IW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int unsigned CW = $clog2(STREAMS + 1);
  localparam int unsigned QCW = $clog2(QUO_W + 1);

  logic              cmd_q;
  logic [7:0]        idx_q;
  logic [TIME_W-1:0] now_q;
  logic              idx_ok;
  logic [IW-1:0]     ridx;

  logic [TIME_W-1:0] t_rd;
  logic [RATE_W-1:0] r_rd;
  logic [STREAMS-1:0] written_q;
  logic [1:0]        st_q [STREAMS];
  logic [CW-1:0]     dead_q, stale_q;

  logic [TIME_W-1:0] last_q, time_new_q;
  logic [RATE_W-1:0] rate_old_q, rate_new_q;
  logic [1:0]        stat_new_q;
  logic              need_div_q;

  // serial restoring divider state
  logic [QUO_W-1:0]  rem_q, quo_q, numsh_q;
  logic [TIME_W-1:0] div_q;
  logic [QCW-1:0]    cnt_q;
  logic [47:0]       p1_q, p2_q;

  assign idx_ok = ({24'd0, idx_q} < 32'(STREAMS));
  assign ridx = idx_q[IW-1:0];

  logic [TIME_W-1:0] t_eff;
  logic [RATE_W-1:0] r_eff;
  assign t_eff = written_q[ridx] ? t_rd : '0;
  assign r_eff = written_q[ridx] ? r_rd : '0;

  slrm_ram #(.WIDTH(TIME_W), .DEPTH(STREAMS)) u_time (
    .clk_i, .we_i(ctrl_i.write), .waddr_i(ridx), .wdata_i(time_new_q),
    .raddr_i(ridx), .rdata_o(t_rd));
  slrm_ram #(.WIDTH(RATE_W), .DEPTH(STREAMS)) u_rate (
    .clk_i, .we_i(ctrl_i.write), .waddr_i(ridx), .wdata_i(rate_new_q),
    .raddr_i(ridx), .rdata_o(r_rd));

  // classification of the read entry
  logic              neg;
  logic [TIME_W-1:0] gap;
  logic [1:0]        cls, st_eval;
  logic              nd_eval;
  always_comb begin
    neg = now_q < t_eff;
    gap = neg ? (t_eff - now_q) : (now_q - t_eff);
    if (neg) cls = ST_OK;
    else if (gap > {31'd0, dead_thr_i}) cls = ST_DEAD;
    else if (gap > {31'd0, stale_thr_i}) cls = ST_STALE;
    else cls = ST_OK;
    nd_eval = 1'b0;
    if (cmd_q == CMD_ARRIVAL) begin
      if (t_eff == '0) st_eval = ST_OK;
      else begin
        st_eval = cls;
        nd_eval = !neg && (gap != '0);
      end
    end else begin
      st_eval = (t_eff == '0) ? ST_DEAD : cls;
    end
  end

  // divider trial subtract
  logic [QUO_W:0]    trial;
  logic [QUO_W-1:0]  rem_sh;
  logic              fits;
  always_comb begin
    rem_sh = {rem_q[QUO_W-2:0], numsh_q[QUO_W-1]};
    fits = ({25'd0, rem_q[QUO_W-1], rem_sh} >= {1'b0, div_q});
    trial = {1'b0, rem_sh} - div_q[QUO_W:0];
  end

  logic [RATE_W-1:0] inst;
  assign inst = (quo_q > {14'd0, RATE_MAX}) ? RATE_MAX : quo_q[RATE_W-1:0];

  logic [48:0] acc;
  assign acc = {1'b0, p1_q} + {1'b0, p2_q} + 49'd32768;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= command_i;
      idx_q <= topic_index_i;
      now_q <= now_time_i;
    end
    if (ctrl_i.eval) begin
      last_q <= t_eff;
      rate_old_q <= r_eff;
      rate_new_q <= r_eff;
      stat_new_q <= st_eval;
      need_div_q <= nd_eval;
      time_new_q <= (cmd_q == CMD_ARRIVAL) ? now_q : t_eff;
    end
    if (ctrl_i.div_start) begin
      rem_q <= '0;
      quo_q <= '0;
      numsh_q <= RATE_NUM;
      div_q <= gap;
      cnt_q <= QCW'(QUO_W);
    end else if (ctrl_i.div_step && cnt_q != '0) begin
      // dividers wider than the remainder never fit
      if (fits && div_q[TIME_W-1:QUO_W] == '0) begin
        rem_q <= trial[QUO_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
      numsh_q <= {numsh_q[QUO_W-2:0], 1'b0};
      cnt_q <= cnt_q - 1'b1;
    end
    if (ctrl_i.mul) begin
      p1_q <= {32'd0, ema_w_i} * {24'd0, inst};
      p2_q <= {24'd0, 24'(17'd65536 - {1'b0, ema_w_i})} * {24'd0, rate_old_q};
    end
    if (ctrl_i.avg) begin
      rate_new_q <= (acc[48:16] > {9'd0, RATE_MAX}) ? RATE_MAX : acc[16+RATE_W-1:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      dead_q <= CW'(STREAMS);
      stale_q <= '0;
      for (int i = 0; i < STREAMS; i++) st_q[i] <= ST_DEAD;
    end else if (ctrl_i.write) begin
      written_q[ridx] <= 1'b1;
      st_q[ridx] <= stat_new_q;
      dead_q <= dead_q - CW'(st_q[ridx] == ST_DEAD) + CW'(stat_new_q == ST_DEAD);
      stale_q <= stale_q - CW'(st_q[ridx] == ST_STALE) + CW'(stat_new_q == ST_STALE);
    end
  end

  assign stat_o.idx_ok = idx_ok;
  assign stat_o.need_div = idx_ok && nd_eval;
  assign stat_o.div_done = (cnt_q == '0);

  assign index_valid_o = idx_ok;
  assign stream_status_o = idx_ok ? st_q[ridx] : ST_DEAD;
  assign rate_estimate_o = idx_ok ? rate_new_q : '0;
  assign last_arrival_o = idx_ok ? time_new_q : '0;
  assign system_status_o = (dead_q != '0) ? ST_DEAD : (stale_q != '0) ? ST_STALE : ST_OK;
endmodule

>>> sv/stream_liveness_rate_monitor.sv
// Top level of the per-stream liveness and arrival rate monitor.
// Usage:
//   in_if  (sink):   one transaction carries command, topic_index, now_time.
//   out_if (source): one result transaction per input transaction, with
//                    index_valid, stream_status, rate_estimate, last_arrival
//                    and system_status.
//   cfg: write enable, register index, data; 0 stale, 1 dead, 2 weight.
// Sequence: checks, priming and zero or negative gaps go through the read,
//   evaluate and write-back states to the result; an arrival that updates
//   the rate also runs the 38-step serial restoring divider of 256e9 by the
//   gap, plus a multiply and an add stage.
//   Out-of-range indexes skip the write-back state.
// Flow: one transaction at a time; the next one is taken in the cycle after
//   the result is taken.
// Reset: all streams unprimed and dead, rates zero, registers at defaults.
//   Per-entry written bits stand in for a clearing pass, so no sweep is needed.
// Stall: the result holds on out_if until ready; no new input is taken.
module stream_liveness_rate_monitor import slrm_pkg::*; #(
  parameter int unsigned STREAMS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slrm_in_if.sink     in_if,
  slrm_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  ctrl_t ctrl;
  stat_t stat;
  logic [31:0] stale_q, dead_q;
  logic [15:0] ema_q;

  // hold configuration registers; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q <= 32'd200000000;
      dead_q  <= 32'd1000000000;
      ema_q   <= 16'd6554;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STALE: stale_q <= cfg_data_i;
        CFG_DEAD:  dead_q <= cfg_data_i;
        CFG_EMA:   ema_q <= cfg_data_i[15:0];
        default:   ;
      endcase
    end
  end

  slrm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_ready_i(out_if.ready), .stat_i(stat), .ctrl_o(ctrl));

  slrm_dp #(.STREAMS(STREAMS)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .command_i(in_if.command), .topic_index_i(in_if.topic_index),
    .now_time_i(in_if.now_time), .stale_thr_i(stale_q), .dead_thr_i(dead_q),
    .ema_w_i(ema_q), .index_valid_o(out_if.index_valid),
    .stream_status_o(out_if.stream_status), .rate_estimate_o(out_if.rate_estimate),
    .last_arrival_o(out_if.last_arrival), .system_status_o(out_if.system_status));

  assign out_if.valid = ctrl.out_valid;

  // never accept a new transaction while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("input taken with result pending");
  // a stalled result keeps its stream status and rate estimate
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> $stable(out_if.stream_status)
      && $stable(out_if.rate_estimate)) else $error("result changed while stalled");
  // divider runs only on in-range arrivals
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.div_start |-> stat.idx_ok) else $error("divide on invalid index");
endmodule

>>> tb/sv/tb_stream_liveness_rate_monitor.sv
// Self-checking testbench of the stream liveness and arrival rate monitor.
module tb_stream_liveness_rate_monitor;
  import slrm_pkg::*;

  localparam int unsigned    NSTR       = 16;
  localparam logic [1:0]     CFG_UNUSED = 2'd3;   // no register behind this index
  localparam longint unsigned TIME_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int             DRAIN_CYC  = 60;     // longer than the slowest result

  typedef struct packed {
    logic        index_valid;
    logic [1:0]  stream_status;
    logic [23:0] rate_estimate;
    logic [62:0] last_arrival;
    logic [1:0]  system_status;
  } result_t;

  // Liveness predictor plus the queue of results it expects.
  class liveness_board;
    longint unsigned arrival[NSTR];
    longint unsigned rate[NSTR];
    status_e         status[NSTR];
    int              dead_cnt;
    int              stale_cnt;
    longint unsigned stale_thr;
    longint unsigned dead_thr;
    longint unsigned weight;
    result_t         expected_q[$];
    int              errors;

    function new();
      for (int i = 0; i < NSTR; i++) begin
        arrival[i] = 0;
        rate[i]    = 0;
        status[i]  = ST_DEAD;
      end
      dead_cnt  = NSTR;
      stale_cnt = 0;
      stale_thr = 200000000;
      dead_thr  = 1000000000;
      weight    = 6554;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_STALE: stale_thr = data;
        CFG_DEAD:  dead_thr  = data;
        CFG_EMA:   weight    = data[15:0];
        default: ;
      endcase
    endfunction

    function void move_status(int i, status_e st);
      if (status[i] == st) return;
      if (status[i] == ST_DEAD) dead_cnt--;
      else if (status[i] == ST_STALE) stale_cnt--;
      if (st == ST_DEAD) dead_cnt++;
      else if (st == ST_STALE) stale_cnt++;
      status[i] = st;
    endfunction

    // Backward gaps pass no threshold; dead is tested before stale.
    function status_e grade_gap(bit neg, longint unsigned gap);
      if (neg) return ST_OK;
      if (gap > dead_thr) return ST_DEAD;
      if (gap > stale_thr) return ST_STALE;
      return ST_OK;
    endfunction

    function void note_input(logic cmd, logic [7:0] idx, logic [62:0] now_t);
      longint unsigned now_v, last, gap, inst, acc;
      bit              neg;
      int              i;
      result_t         r;
      now_v = {1'b0, now_t};
      r = '0;
      if (idx < NSTR) begin
        i    = idx;
        last = arrival[i];
        neg  = now_v < last;
        gap  = neg ? last - now_v : now_v - last;
        if (cmd == CMD_ARRIVAL) begin
          if (last == 0) begin
            arrival[i] = now_v;
            move_status(i, ST_OK);
          end else begin
            move_status(i, grade_gap(neg, gap));
            if (!neg && gap != 0) begin
              inst = 64'(RATE_NUM) / gap;
              if (inst > RATE_MAX) inst = RATE_MAX;
              acc = (weight * inst + (65536 - weight) * rate[i] + 32768) >> 16;
              if (acc > RATE_MAX) acc = RATE_MAX;
              rate[i] = acc;
            end
            arrival[i] = now_v;
          end
        end else begin
          if (last == 0) move_status(i, ST_DEAD);
          else move_status(i, grade_gap(neg, gap));
        end
        r.index_valid   = 1'b1;
        r.stream_status = status[i];
        r.rate_estimate = rate[i][23:0];
        r.last_arrival  = arrival[i][62:0];
      end else begin
        r.stream_status = ST_DEAD;
      end
      r.system_status = (dead_cnt != 0) ? ST_DEAD : (stale_cnt != 0) ? ST_STALE : ST_OK;
      expected_q = {expected_q, r};
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected iv=%0d st=%0d rate=%0d last=%0d sys=%0d,",
                   exp_r.index_valid, exp_r.stream_status, exp_r.rate_estimate,
                   exp_r.last_arrival, exp_r.system_status,
                   " got iv=%0d st=%0d rate=%0d last=%0d sys=%0d",
                   got.index_valid, got.stream_status, got.rate_estimate,
                   got.last_arrival, got.system_status);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  bit          calm = 1'b0;   // set to suppress idling on both sides

  slrm_in_if  in_if ();
  slrm_out_if out_if ();

  liveness_board board = new();

  stream_liveness_rate_monitor #(.STREAMS(NSTR)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side backpressure: drop ready in about a fifth of the cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_result({out_if.index_valid, out_if.stream_status, out_if.rate_estimate,
                          out_if.last_arrival, out_if.system_status});
    end
  end

  // Present one input transaction, hold it until taken, then predict.
  task automatic send_item(logic cmd, logic [7:0] idx, logic [62:0] now_t);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.topic_index <= idx;
    in_if.now_time    <= now_t;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_input(cmd, idx, now_t);
  endtask

  // Drain all pending results and let the block fall idle.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pick a time for stream i: mostly forward gaps around the interesting
  // rate and threshold boundaries, sometimes zero, backward or wild.
  function automatic logic [62:0] pick_time(int i);
    longint unsigned last, gap;
    last = (i < NSTR) ? board.arrival[i] : 64'd0;
    case ($urandom_range(0, 11))
      0:       gap = $urandom_range(1, 20000);                  // saturated rate for gaps up to 15258
      1, 2:    gap = $urandom_range(15000, 5000000);
      3:       gap = board.stale_thr + $urandom_range(0, 2) - 1;
      4:       gap = board.dead_thr + $urandom_range(0, 2) - 1;
      5, 6:    gap = $urandom_range(1, 1500000000);
      7:       gap = {$urandom_range(0, 3), $urandom()};
      8:       gap = 0;
      9:       return 63'(last - $urandom_range(1, 1000));     // backwards
      10:      return 63'({$urandom(), $urandom()});
      default: gap = $urandom_range(100000, 300000000);
    endcase
    return 63'((last + gap) & TIME_MASK);
  endfunction

  task automatic run_random(int n);
    logic       cmd;
    logic [7:0] idx;
    for (int k = 0; k < n; k++) begin
      cmd = ($urandom_range(0, 99) < 80) ? CMD_ARRIVAL : CMD_CHECK;
      if ($urandom_range(0, 99) < 92) idx = 8'($urandom_range(0, NSTR - 1));
      else idx = 8'($urandom_range(NSTR, 255));
      send_item(cmd, idx, pick_time(idx));
    end
  endtask

  initial begin
    in_if.valid       <= 1'b0;
    in_if.command     <= CMD_ARRIVAL;
    in_if.topic_index <= '0;
    in_if.now_time    <= '0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_STALE;
    cfg_data_i        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: out-of-range, unprimed checks, time zero priming, edges of gaps.
    send_item(CMD_ARRIVAL, 8'd255, 63'h7FFF_FFFF_FFFF_FFFF);
    send_item(CMD_CHECK,   8'(NSTR), 63'd5);
    send_item(CMD_CHECK,   8'd0, 63'd100);                  // unprimed check goes dead
    send_item(CMD_ARRIVAL, 8'd1, 63'd0);                    // primes at zero, stays unprimed
    send_item(CMD_ARRIVAL, 8'd1, 63'd5);
    send_item(CMD_ARRIVAL, 8'd2, 63'd1000);
    send_item(CMD_ARRIVAL, 8'd2, 63'd1000);                 // zero gap
    send_item(CMD_ARRIVAL, 8'd2, 63'd1001);                 // gap of one saturates
    send_item(CMD_ARRIVAL, 8'd2, 63'd1001 + 63'd200000000); // exactly stale limit
    send_item(CMD_ARRIVAL, 8'd2, 63'd1002 + 63'd400000000); // just above stale
    send_item(CMD_ARRIVAL, 8'd2, 63'd1002 + 63'd1400000000);// exactly dead limit
    send_item(CMD_ARRIVAL, 8'd2, 63'd1003 + 63'd2400000000);// just above dead
    send_item(CMD_ARRIVAL, 8'd2, 63'd7);                    // backwards
    send_item(CMD_CHECK,   8'd2, 63'd7 + 63'd300000000);
    send_item(CMD_CHECK,   8'd2, 63'd3);
    send_item(CMD_ARRIVAL, 8'd3, 63'h7FFF_FFFF_FFFF_FFFF);
    send_item(CMD_ARRIVAL, 8'd3, 63'd1);
    send_item(CMD_ARRIVAL, 8'd3, 63'h7FFF_FFFF_FFFF_FFFF);
    send_item(CMD_ARRIVAL, 8'd15, 63'h2AAA_AAAA_AAAA_AAAA);
    send_item(CMD_CHECK,   8'd15, 63'h5555_5555_5555_5555);
    for (int i = 0; i < NSTR; i++) send_item(CMD_ARRIVAL, 8'(i), 63'(1000 + i));
    run_random(300);
    drain();

    // Zero thresholds and weight; an unused index must change nothing.
    write_reg(CFG_STALE, 32'd0);
    write_reg(CFG_DEAD, 32'd0);
    write_reg(CFG_EMA, 32'd0);
    write_reg(CFG_UNUSED, $urandom());
    run_random(300);
    drain();

    // Top of range, with a long stretch free of idling.
    write_reg(CFG_STALE, 32'hFFFF_FFFF);
    write_reg(CFG_DEAD, 32'hFFFF_FFFF);
    write_reg(CFG_EMA, 32'h0000_FFFF);
    calm = 1'b1;
    run_random(300);
    calm = 1'b0;
    drain();

    // Random settings, stale below dead most of the time.
    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_STALE, $urandom_range(1000, 400000000));
      write_reg(CFG_DEAD, $urandom_range(1000, 1500000000));
      write_reg(CFG_EMA, $urandom());
      run_random(130);
      drain();
    end

    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> stream_liveness_rate_monitor.f
sv/slrm_pkg.sv
sv/slrm_stream_if.sv
sv/slrm_ram.sv
sv/slrm_ctrl.sv
sv/slrm_dp.sv
sv/stream_liveness_rate_monitor.sv
tb/sv/tb_stream_liveness_rate_monitor.sv
